// ===== rtl/core/generational_slot_allocator_defines.svh =====
// Assertion macros for the generational slot allocator.
// No dependencies; included by the modules that carry assertions.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GSA_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("gsa: invariant violated");
`define GSA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsa: implication violated");
`define GSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsa: next-cycle check violated");
`else
`define GSA_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define GSA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define GSA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/gsa_pkg.sv =====
// Shared types and codes for the generational slot allocator.
// No dependencies.
package gsa_pkg;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_ALLOC  = 2'd1;
  localparam logic [1:0] MODE_FREE   = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

  localparam logic [8:0] MAX_SLOTS_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] handle_index;
    logic [31:0] handle_generation;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_index;
    logic [31:0] slot_generation;
    logic [8:0]  live_slots;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/gsa_ctrl.sv =====
// Controller: request sequencing and result handshake.
// Depends on gsa_pkg and generational_slot_allocator_defines.svh.
`include "generational_slot_allocator_defines.svh"

module gsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output gsa_pkg::ctrl_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.exec) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  `GSA_ASSERT_NEXT(a_accept_then_busy, clk, rst, req_valid && req_ready, !req_ready)
  `GSA_ASSERT_IMPLIES(a_exec_slot_free, clk, rst, cmd.exec, !rsp_valid || rsp_ready)
  `GSA_ASSERT_NEXT(a_exec_then_valid, clk, rst, cmd.exec, rsp_valid)

endmodule

// ===== rtl/core/gsa_datapath.sv =====
// Datapath: generation/active memory, free stack, counters, result register.
// Depends on gsa_pkg and generational_slot_allocator_defines.svh.
`include "generational_slot_allocator_defines.svh"

module gsa_datapath #(
  parameter int SLOT_COUNT = 256,
  parameter int FREE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  gsa_pkg::ctrl_cmd_t cmd,
  input  gsa_pkg::req_t      req,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_max_slots,
  output gsa_pkg::rsp_t      rsp
);

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int TOP_W   = $clog2(FREE_DEPTH + 1);
  localparam int SADDR_W = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;

  typedef struct packed {
    logic        active;
    logic [31:0] gen;
  } slot_ent_t;

  // Entries at or above high_water are not written since reset; handle checks treat them as inactive.
  slot_ent_t        slot_mem [0:SLOT_COUNT-1];
  logic [IDX_W-1:0] free_mem [0:FREE_DEPTH-1];

  logic [8:0]       max_slots;
  logic [TOP_W-1:0] free_top;
  logic [CNT_W-1:0] live_count;
  logic [CNT_W-1:0] high_water;
  logic [31:0]      next_gen;

  gsa_pkg::req_t    cur;
  slot_ent_t        rd_ent;
  logic [IDX_W-1:0] rd_slot;

  logic [32:0]      eff_limit;
  logic [IDX_W-1:0] cur_idx;
  logic [TOP_W-1:0] top_m1;
  logic             handle_ok;
  logic             from_stack;
  logic             fresh_ok;
  logic [IDX_W-1:0] alloc_slot;

  logic             slot_we;
  logic [IDX_W-1:0] slot_waddr;
  slot_ent_t        slot_wdata;
  logic             free_we;

  logic [TOP_W-1:0] free_top_next;
  logic [CNT_W-1:0] live_count_next;
  logic [CNT_W-1:0] high_water_next;
  logic [31:0]      next_gen_next;
  gsa_pkg::rsp_t    rsp_next;
  logic [31:0]      r_idx;

  assign eff_limit = ({24'd0, max_slots} < 33'(SLOT_COUNT)) ? {24'd0, max_slots}
                                                             : 33'(SLOT_COUNT);
  assign cur_idx = cur.handle_index[IDX_W-1:0];
  assign top_m1  = free_top - 1'b1;

  assign handle_ok = !((cur.handle_index == 32'd0) && (cur.handle_generation == 32'd0))
                   && ({1'b0, cur.handle_index} < eff_limit)
                   && (33'(cur_idx) < 33'(high_water))
                   && rd_ent.active
                   && (rd_ent.gen == cur.handle_generation);

  assign from_stack = (free_top != '0);
  assign fresh_ok   = 33'(high_water) < eff_limit;
  assign alloc_slot = from_stack ? rd_slot : high_water[IDX_W-1:0];

  always_comb begin
    free_top_next   = free_top;
    live_count_next = live_count;
    high_water_next = high_water;
    next_gen_next   = next_gen;
    slot_we         = 1'b0;
    slot_waddr      = cur_idx;
    slot_wdata      = '{active: 1'b0, gen: cur.handle_generation + 32'd1};
    free_we         = 1'b0;
    r_idx           = 32'd0;
    rsp_next.status          = gsa_pkg::STATUS_INVALID;
    rsp_next.slot_generation = 32'd0;
    unique case (cur.mode)
      gsa_pkg::MODE_LOOKUP: begin
        if (handle_ok) begin
          rsp_next.status          = gsa_pkg::STATUS_OK;
          r_idx                    = cur.handle_index;
          rsp_next.slot_generation = cur.handle_generation;
        end
      end
      gsa_pkg::MODE_ALLOC: begin
        if (from_stack || fresh_ok) begin
          slot_we    = 1'b1;
          slot_waddr = alloc_slot;
          slot_wdata = '{active: 1'b1, gen: next_gen};
          if (from_stack) begin
            free_top_next = top_m1;
          end else begin
            high_water_next = high_water + 1'b1;
          end
          next_gen_next            = next_gen + 32'd1;
          live_count_next          = live_count + 1'b1;
          rsp_next.status          = gsa_pkg::STATUS_OK;
          r_idx                    = 32'(alloc_slot);
          rsp_next.slot_generation = next_gen;
        end else begin
          rsp_next.status = gsa_pkg::STATUS_NO_SLOT;
        end
      end
      gsa_pkg::MODE_FREE: begin
        if (handle_ok) begin
          slot_we = 1'b1;
          if (32'(free_top) < 32'(FREE_DEPTH)) begin
            free_we       = 1'b1;
            free_top_next = free_top + 1'b1;
          end
          if (live_count != '0) begin
            live_count_next = live_count - 1'b1;
          end
          rsp_next.status          = gsa_pkg::STATUS_OK;
          r_idx                    = cur.handle_index;
          rsp_next.slot_generation = cur.handle_generation;
        end
      end
      default: ;
    endcase
    rsp_next.slot_index = r_idx[7:0];
    rsp_next.live_slots = 9'(32'(live_count_next));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur     <= req;
      rd_ent  <= slot_mem[req.handle_index[IDX_W-1:0]];
      rd_slot <= free_mem[top_m1[SADDR_W-1:0]];
    end
    if (cmd.exec && slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (cmd.exec && free_we) begin
      free_mem[free_top[SADDR_W-1:0]] <= cur_idx;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_slots  <= gsa_pkg::MAX_SLOTS_RESET;
      free_top   <= '0;
      live_count <= '0;
      high_water <= '0;
      next_gen   <= 32'd1;
    end else begin
      if (cfg_we) begin
        max_slots <= cfg_max_slots;
      end
      if (cmd.exec) begin
        free_top   <= free_top_next;
        live_count <= live_count_next;
        high_water <= high_water_next;
        next_gen   <= next_gen_next;
      end
    end
  end

  `GSA_ASSERT_ALWAYS(a_live_le_hw, clk, rst, live_count <= high_water)
  `GSA_ASSERT_ALWAYS(a_top_bound, clk, rst, 32'(free_top) <= 32'(FREE_DEPTH))
  `GSA_ASSERT_ALWAYS(a_hw_bound, clk, rst, 32'(high_water) <= 32'(SLOT_COUNT))

endmodule

// ===== rtl/core/generational_slot_allocator.sv =====
// Top level of the generational slot allocator.
// Depends on gsa_pkg, gsa_ctrl and gsa_datapath.
//
//   channel  signals                          payload
//   req      req_valid / req_ready            gsa_pkg::req_t
//   rsp      rsp_valid / rsp_ready            gsa_pkg::rsp_t
//   cfg      cfg_valid / cfg_ready            max_slots, 9 bits
//
// Each request is accepted in ST_IDLE, which reads the slot memory and the
// free stack; ST_EXEC then updates them and loads the result register.
// ST_EXEC holds while a previous result is still not taken.
// Slots at or above the high-water mark read as inactive,
// so the slot memory needs no clearing pass. Config writes land at once.
module generational_slot_allocator #(
  parameter int SLOT_COUNT = 256,
  parameter int FREE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  gsa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output gsa_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [8:0]    cfg_max_slots
);

  gsa_pkg::ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  gsa_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .FREE_DEPTH (FREE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req           (req),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_max_slots (cfg_max_slots),
    .rsp           (rsp)
  );

endmodule

// ===== test/slot_allocator_checker.sv =====
// Response checker for the generational slot allocator: tracks slot, free stack
// and generation state from accepted requests and max_slots writes, and checks
// every response in order. Depends on gsa_pkg.
module slot_allocator_checker #(
  parameter int SLOT_COUNT = 256,
  parameter int FREE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  gsa_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  gsa_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [8:0]    cfg_max_slots,
  output int            mismatches,
  output int            outstanding
);
  import gsa_pkg::*;

  logic [31:0] slot_gen [SLOT_COUNT];
  logic        slot_live [SLOT_COUNT];
  logic [7:0]  recycled [FREE_DEPTH];
  int unsigned recycled_top;
  int unsigned live_total;
  int unsigned fresh_mark;
  logic [31:0] gen_counter;
  logic [8:0]  slot_limit_reg;

  rsp_t pending_rsp[$];
  rsp_t want;

  function automatic int unsigned slot_limit();
    return (slot_limit_reg < SLOT_COUNT) ? int'(slot_limit_reg) : SLOT_COUNT;
  endfunction

  function automatic bit handle_live(input logic [31:0] idx, input logic [31:0] gen);
    if (idx == 32'd0 && gen == 32'd0)
      return 1'b0;
    if (idx >= slot_limit())
      return 1'b0;
    if (!slot_live[idx[7:0]])
      return 1'b0;
    return slot_gen[idx[7:0]] == gen;
  endfunction

  // Updates the slot state for one request and returns the response it should give.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t res;
    logic [7:0] slot;
    bit got;
    res = '0;
    res.status = STATUS_INVALID;
    slot = 8'd0;
    got = 1'b0;
    case (r.mode)
      MODE_LOOKUP: begin
        if (handle_live(r.handle_index, r.handle_generation)) begin
          res.status = STATUS_OK;
          res.slot_index = r.handle_index[7:0];
          res.slot_generation = r.handle_generation;
        end
      end
      MODE_ALLOC: begin
        if (recycled_top > 0) begin
          recycled_top--;
          slot = recycled[recycled_top];
          got = 1'b1;
        end else if (fresh_mark < slot_limit()) begin
          slot = 8'(fresh_mark);
          fresh_mark++;
          got = 1'b1;
        end
        if (got) begin
          slot_gen[slot] = gen_counter;
          slot_live[slot] = 1'b1;
          res.status = STATUS_OK;
          res.slot_index = slot;
          res.slot_generation = gen_counter;
          gen_counter++;
          live_total++;
        end else begin
          res.status = STATUS_NO_SLOT;
        end
      end
      MODE_FREE: begin
        if (handle_live(r.handle_index, r.handle_generation)) begin
          slot = r.handle_index[7:0];
          slot_live[slot] = 1'b0;
          slot_gen[slot] = slot_gen[slot] + 32'd1;
          // full stack: the index is dropped for good
          if (recycled_top < FREE_DEPTH) begin
            recycled[recycled_top] = slot;
            recycled_top++;
          end
          if (live_total > 0)
            live_total--;
          res.status = STATUS_OK;
          res.slot_index = slot;
          res.slot_generation = r.handle_generation;
        end
      end
      default: ;
    endcase
    res.live_slots = 9'(live_total);
    return res;
  endfunction

  task automatic report_mismatch(input rsp_t exp_rsp, input rsp_t act_rsp);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: response mismatch: expected status %0d index %0d gen %08h live %0d,",
               $time, exp_rsp.status, exp_rsp.slot_index, exp_rsp.slot_generation,
               exp_rsp.live_slots);
    if (mismatches <= 10)
      $display("  got status %0d index %0d gen %08h live %0d",
               act_rsp.status, act_rsp.slot_index, act_rsp.slot_generation,
               act_rsp.live_slots);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++)
        slot_live[i] = 1'b0;
      recycled_top = 0;
      live_total = 0;
      fresh_mark = 0;
      gen_counter = 32'd1;
      slot_limit_reg = MAX_SLOTS_RESET;
      pending_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        slot_limit_reg = cfg_max_slots;
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: response with no request outstanding: status %0d index %0d",
                     $time, rsp.status, rsp.slot_index);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status || rsp.slot_index !== want.slot_index ||
              rsp.slot_generation !== want.slot_generation ||
              rsp.live_slots !== want.live_slots)
            report_mismatch(want, rsp);
        end
      end
      if (req_valid && req_ready)
        pending_rsp.push_back(apply_request(req));
    end
    outstanding <= pending_rsp.size();
  end

endmodule

// ===== test/generational_slot_allocator_test.sv =====
// Testbench top for generational_slot_allocator: drives requests, max_slots writes
// and response backpressure, and gives the verdict from slot_allocator_checker.
// Depends on gsa_pkg, generational_slot_allocator and slot_allocator_checker.
module generational_slot_allocator_test;
  import gsa_pkg::*;

  typedef struct packed {
    logic [31:0] index;
    logic [31:0] gen;
  } handle_t;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RSP_HOLD_CYCLES = 300;
  localparam int RETIRED_KEEP = 32;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_max_slots = MAX_SLOTS_RESET;

  int mismatches;
  int outstanding;

  int unsigned send_idle_pct = 0;
  int unsigned rsp_idle_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned max_slots_writes = 0;
  int unsigned ok_seen = 0;
  int unsigned invalid_seen = 0;
  int unsigned no_slot_seen = 0;

  req_t    in_flight[$];
  handle_t live_pool[$];
  handle_t retired[$];
  req_t    done_req;
  handle_t seen;
  int      pool_pos;

  generational_slot_allocator dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_max_slots(cfg_max_slots)
  );

  slot_allocator_checker slot_check (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_max_slots(cfg_max_slots),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               outstanding);
      $display("generational_slot_allocator test failed");
      $finish;
    end
  end

  // response side: random backpressure, plus a long stall on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      rsp_ready <= 1'b0;
      hold_left <= RSP_HOLD_CYCLES;
      hold_served <= hold_asked;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // harvest handles from responses to build well-formed requests
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready && in_flight.size() != 0) begin
      done_req = in_flight.pop_front();
      seen.index = {24'd0, rsp.slot_index};
      seen.gen = rsp.slot_generation;
      case (rsp.status)
        STATUS_OK:      ok_seen++;
        STATUS_NO_SLOT: no_slot_seen++;
        default:        invalid_seen++;
      endcase
      if (rsp.status == STATUS_OK && done_req.mode == MODE_ALLOC) begin
        live_pool.push_back(seen);
      end else if (rsp.status == STATUS_OK && done_req.mode == MODE_FREE) begin
        for (pool_pos = 0; pool_pos < live_pool.size(); pool_pos++) begin
          if (live_pool[pool_pos] == seen) begin
            live_pool.delete(pool_pos);
            break;
          end
        end
        retired.push_back(seen);
        if (retired.size() > RETIRED_KEEP)
          void'(retired.pop_front());
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [31:0] idx,
                              input logic [31:0] gen);
    req_t item;
    item.mode = op;
    item.handle_index = idx;
    item.handle_generation = gen;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    in_flight.push_back(item);
    requests_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_max_slots(input logic [8:0] limit);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_max_slots <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_slots_writes++;
  endtask

  // stale, corrupted, null, out-of-range and unused-mode requests
  task automatic send_noise();
    handle_t h;
    logic [1:0] op;
    op = 2'($urandom_range(3));
    h.index = $urandom;
    h.gen = $urandom;
    case ($urandom_range(3))
      0: ;
      1: begin
        if (retired.size() != 0)
          h = retired[$urandom_range(retired.size() - 1)];
      end
      2: begin
        if (live_pool.size() != 0) begin
          h = live_pool[$urandom_range(live_pool.size() - 1)];
          if ($urandom_range(1) == 1)
            h.gen = h.gen ^ (32'd1 << $urandom_range(31));
          else
            h.index[31:8] = 24'($urandom_range(24'hFF_FFFF, 1));
        end
      end
      default: begin
        h.index = 32'd0;
        h.gen = 32'd0;
      end
    endcase
    send_request(op, h.index, h.gen);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned pool_goal);
    int unsigned roll;
    int unsigned alloc_share;
    handle_t h;
    repeat (count) begin
      roll = $urandom_range(99);
      alloc_share = (live_pool.size() < pool_goal) ? 55 : 20;
      if (roll < alloc_share) begin
        send_request(MODE_ALLOC, $urandom, $urandom);
      end else if (roll < 90 && live_pool.size() != 0) begin
        h = live_pool[$urandom_range(live_pool.size() - 1)];
        if (roll < alloc_share + 25)
          send_request(MODE_LOOKUP, h.index, h.gen);
        else
          send_request(MODE_FREE, h.index, h.gen);
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    handle_t burst[$];
    int i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    rsp_idle_pct <= 82;

    send_request(MODE_LOOKUP, 32'd0, 32'd0);
    send_request(MODE_FREE, 32'd0, 32'd0);
    send_request(MODE_UNUSED, $urandom, $urandom);
    send_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_LOOKUP, 32'd0, 32'd1);
    send_request(MODE_LOOKUP, 32'h100, 32'd1);
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_LOOKUP, 32'd0, 32'd2);
    send_request(MODE_FREE, 32'd0, 32'd1);
    send_request(MODE_LOOKUP, 32'd0, 32'd1);
    send_request(MODE_ALLOC, 32'd0, 32'd0);
    send_request(MODE_FREE, 32'd0, 32'd1);
    write_max_slots(9'd0);
    send_request(MODE_ALLOC, 32'd0, 32'd0);
    send_request(MODE_LOOKUP, 32'd0, 32'd2);
    write_max_slots(9'h1FF);
    send_request(MODE_LOOKUP, 32'd0, 32'd2);
    send_request(MODE_ALLOC, 32'd0, 32'd0);
    send_request(MODE_FREE, 32'd1, 32'd3);
    // limit lowered below a freed index: it is still handed out from the stack
    write_max_slots(9'd1);
    send_request(MODE_ALLOC, 32'd0, 32'd0);
    send_request(MODE_LOOKUP, 32'd1, 32'd4);
    send_request(MODE_ALLOC, 32'd0, 32'd0);
    write_max_slots(MAX_SLOTS_RESET);
    send_request(MODE_LOOKUP, 32'd1, 32'd4);
    send_request(MODE_LOOKUP, 32'd255, 32'd0);

    run_random(150, 8);
    write_max_slots(9'($urandom_range(511)));
    run_random(150, 40);
    write_max_slots(9'd24);
    run_random(150, 16);
    write_max_slots(MAX_SLOTS_RESET);
    run_random(150, 48);

    send_idle_pct = 82;
    rsp_idle_pct <= 15;
    write_max_slots(9'h1FF);
    run_random(150, 32);
    write_max_slots(9'd8);
    run_random(150, 6);
    write_max_slots(9'($urandom_range(511)));
    run_random(150, 24);
    write_max_slots(MAX_SLOTS_RESET);
    run_random(150, 40);

    send_idle_pct = 0;
    rsp_idle_pct <= 0;
    // keep offering requests through a long response stall
    hold_asked <= hold_asked + 1;
    run_random(24, 40);

    // overflow the free stack: many live slots, then free more than it holds
    wait_drained();
    repeat (80) send_request(MODE_ALLOC, $urandom, $urandom);
    wait_drained();
    burst = live_pool;
    for (i = 0; i < burst.size() && i < 72; i++)
      send_request(MODE_FREE, burst[i].index, burst[i].gen);
    repeat (72) send_request(MODE_ALLOC, $urandom, $urandom);

    write_max_slots(9'($urandom_range(511)));
    run_random(225, 32);
    write_max_slots(9'h1FF);
    run_random(225, 56);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d requests: %0d ok, %0d rejected handles or modes, %0d with no slot free",
             requests_sent, ok_seen, invalid_seen, no_slot_seen);
    $display("%0d max_slots writes, three backpressure profiles, one %0d-cycle stall",
             max_slots_writes, RSP_HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0)
      $display("generational_slot_allocator test passed");
    else
      $display("generational_slot_allocator test failed");
    $finish;
  end

endmodule
